[rtl/mcdm_pkg.sv]
// shared constants and field widths for the duplex mailbox fifo
`default_nettype none

package mcdm_pkg;

   // field widths of one transfer on either channel
   localparam int KIND_BITS    = 3;
   localparam int CHANNEL_BITS = 4;
   localparam int DATA_BITS    = 32;
   localparam int COUNT_BITS   = 8;

   // operation codes carried in the kind field
   localparam logic [KIND_BITS-1:0] KIND_APP_PUSH = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_DEV_POP  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DEV_PUSH = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_APP_POP  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_STATUS   = 3'd4;

   // saturation value of the occupancy fields
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'hFF;

   typedef logic [KIND_BITS-1:0]    kind_type;
   typedef logic [CHANNEL_BITS-1:0] channel_type;
   typedef logic [DATA_BITS-1:0]    data_type;
   typedef logic [COUNT_BITS-1:0]   count_type;

endpackage

`default_nettype wire

[rtl/mcdm_req_if.sv]
// request channel: valid/ready handshake with kind, channel and write word
`default_nettype none

interface mcdm_req_if;
   logic                  valid;
   logic                  ready;
   mcdm_pkg::kind_type    kind;
   mcdm_pkg::channel_type channel;
   mcdm_pkg::data_type    write_word;

   modport source (output valid, output kind, output channel, output write_word,
                   input ready);
   modport sink   (input valid, input kind, input channel, input write_word,
                   output ready);
endinterface

`default_nettype wire

[rtl/mcdm_rsp_if.sv]
// response channel: valid/ready handshake with status, popped word and counts
`default_nettype none

interface mcdm_rsp_if;
   logic                valid;
   logic                ready;
   logic                ok;
   mcdm_pkg::data_type  read_word;
   mcdm_pkg::count_type down_count;
   mcdm_pkg::count_type up_count;

   modport source (output valid, output ok, output read_word, output down_count,
                   output up_count, input ready);
   modport sink   (input valid, input ok, input read_word, input down_count,
                   input up_count, output ready);
endinterface

`default_nettype wire

[rtl/mcdm_ram.sv]
// generic single write port, single read port ram with registered read data
`default_nettype none

module mcdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/multi_channel_duplex_mailbox_fifo.sv]
// top level of the multi-channel duplex mailbox fifo
`default_nettype none

// Each channel owns a downlink ring (application pushes, device pops) and an
// uplink ring (device pushes, application pops), all held in one shared word
// ram of NUM_CHANNELS * (DOWN_DEPTH + UP_DEPTH) words. A ring keeps at most
// depth - 1 words: a push that would fill the last slot is refused, as is a
// pop from an empty ring. Every request transfer gives exactly one response
// transfer carrying ok, the popped word (zero unless a pop took place) and
// both occupancies after the operation, saturated at 255. A channel index at
// or above NUM_CHANNELS changes nothing and answers all zeros; kinds above
// status behave as status. The block takes one request per cycle while the
// result register is free or drains; a request sits in the input register,
// where the ring pointers of the channel are read, checked and updated and
// the ram is addressed, and its response comes from the ram read register
// together with the result register. The ram has one write port and one
// read port; a push only writes and a pop only reads, and a pop always reads
// a slot written by an earlier push, so no forwarding is needed. The ram
// needs no clearing after reset, since a pop only reaches written slots.
module multi_channel_duplex_mailbox_fifo #(
   parameter int NUM_CHANNELS = 16,
   parameter int DOWN_DEPTH   = 256,
   parameter int UP_DEPTH     = 256,
   parameter int WORD_BITS    = 32
) (
   input wire logic    clock,
   input wire logic    reset,
   mcdm_req_if.sink    req_chan,
   mcdm_rsp_if.source  rsp_chan
);

   localparam int CH_BITS     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DP_BITS     = $clog2(DOWN_DEPTH);
   localparam int UP_BITS     = $clog2(UP_DEPTH);
   localparam int CHAN_SPAN   = DOWN_DEPTH + UP_DEPTH;
   localparam int STORE_WORDS = NUM_CHANNELS * CHAN_SPAN;
   localparam int ADDR_BITS   = $clog2(STORE_WORDS);

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   mcdm_pkg::kind_type    s1_kind_ff;
   mcdm_pkg::channel_type s1_chan_ff;
   mcdm_pkg::data_type    s1_word_ff;

   // result register
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_ok_ff, s2_ok_in;
   logic                  s2_pop_ff, s2_pop_in;
   mcdm_pkg::count_type   s2_dcnt_ff, s2_dcnt_in;
   mcdm_pkg::count_type   s2_ucnt_ff, s2_ucnt_in;

   // per-channel ring pointers
   logic [DP_BITS-1:0] down_head_ff [NUM_CHANNELS];
   logic [DP_BITS-1:0] down_tail_ff [NUM_CHANNELS];
   logic [UP_BITS-1:0] up_head_ff   [NUM_CHANNELS];
   logic [UP_BITS-1:0] up_tail_ff   [NUM_CHANNELS];
   logic [DP_BITS-1:0] down_head_in [NUM_CHANNELS];
   logic [DP_BITS-1:0] down_tail_in [NUM_CHANNELS];
   logic [UP_BITS-1:0] up_head_in   [NUM_CHANNELS];
   logic [UP_BITS-1:0] up_tail_in   [NUM_CHANNELS];

   logic               advance;
   logic               chan_ok;
   logic [CH_BITS-1:0] cidx;
   logic [DP_BITS-1:0] dh, dt, dt_next, dh_next, dh_new, dt_new;
   logic [UP_BITS-1:0] uh, ut, ut_next, uh_next, uh_new, ut_new;
   logic               d_full, d_empty, u_full, u_empty;
   logic               op_ok, op_push, op_pop, op_up;
   logic [DP_BITS:0]   d_occ;
   logic [UP_BITS:0]   u_occ;
   logic [ADDR_BITS-1:0] base_addr, down_addr, up_addr, ram_addr;
   logic [WORD_BITS-1:0] ram_rdata;

   // handshake: stage one moves on when the result register is free or drains
   assign advance        = s1_valid_ff && (!s2_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   // channel look-up
   assign chan_ok = (32'(s1_chan_ff) < NUM_CHANNELS);
   assign cidx    = CH_BITS'(s1_chan_ff);
   assign dh      = down_head_ff[cidx];
   assign dt      = down_tail_ff[cidx];
   assign uh      = up_head_ff[cidx];
   assign ut      = up_tail_ff[cidx];

   // ring pointer advance with wrap at the ring depth
   assign dt_next = (dt == DP_BITS'(DOWN_DEPTH - 1)) ? '0 : dt + 1'b1;
   assign dh_next = (dh == DP_BITS'(DOWN_DEPTH - 1)) ? '0 : dh + 1'b1;
   assign ut_next = (ut == UP_BITS'(UP_DEPTH - 1)) ? '0 : ut + 1'b1;
   assign uh_next = (uh == UP_BITS'(UP_DEPTH - 1)) ? '0 : uh + 1'b1;

   assign d_full  = (dt_next == dh);
   assign d_empty = (dh == dt);
   assign u_full  = (ut_next == uh);
   assign u_empty = (uh == ut);

   // operation decode
   always_comb begin
      op_ok   = 1'b0;
      op_push = 1'b0;
      op_pop  = 1'b0;
      op_up   = 1'b0;
      case (s1_kind_ff)
         mcdm_pkg::KIND_APP_PUSH: begin
            op_push = 1'b1;
            op_ok   = chan_ok && !d_full;
         end
         mcdm_pkg::KIND_DEV_POP: begin
            op_pop = 1'b1;
            op_ok  = chan_ok && !d_empty;
         end
         mcdm_pkg::KIND_DEV_PUSH: begin
            op_push = 1'b1;
            op_up   = 1'b1;
            op_ok   = chan_ok && !u_full;
         end
         mcdm_pkg::KIND_APP_POP: begin
            op_pop = 1'b1;
            op_up  = 1'b1;
            op_ok  = chan_ok && !u_empty;
         end
         mcdm_pkg::KIND_STATUS: begin
            op_ok = 1'b0;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // pointers after the operation
   assign dt_new = (op_ok && op_push && !op_up) ? dt_next : dt;
   assign dh_new = (op_ok && op_pop  && !op_up) ? dh_next : dh;
   assign ut_new = (op_ok && op_push &&  op_up) ? ut_next : ut;
   assign uh_new = (op_ok && op_pop  &&  op_up) ? uh_next : uh;

   // occupancy, one bit wider so the wrap correction fits
   assign d_occ = (DP_BITS+1)'(dt_new) - (DP_BITS+1)'(dh_new)
                + ((dt_new < dh_new) ? (DP_BITS+1)'(DOWN_DEPTH) : '0);
   assign u_occ = (UP_BITS+1)'(ut_new) - (UP_BITS+1)'(uh_new)
                + ((ut_new < uh_new) ? (UP_BITS+1)'(UP_DEPTH) : '0);

   // ram addressing: channel base, then downlink slots, then uplink slots
   assign base_addr = ADDR_BITS'(cidx) * ADDR_BITS'(CHAN_SPAN);
   assign down_addr = base_addr + ADDR_BITS'(op_push ? dt : dh);
   assign up_addr   = base_addr + ADDR_BITS'(DOWN_DEPTH) + ADDR_BITS'(op_push ? ut : uh);
   assign ram_addr  = op_up ? up_addr : down_addr;

   mcdm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (advance && op_ok && op_push),
      .wr_addr (ram_addr),
      .wr_data (WORD_BITS'(s1_word_ff)),
      .rd_en   (advance && op_ok && op_pop),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // next state of the control registers and the pointer tables
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_chan.ready) begin
         s1_valid_in = req_chan.valid;
      end

      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s2_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end

      for (int i = 0; i < NUM_CHANNELS; i++) begin
         down_head_in[i] = down_head_ff[i];
         down_tail_in[i] = down_tail_ff[i];
         up_head_in[i]   = up_head_ff[i];
         up_tail_in[i]   = up_tail_ff[i];
      end
      if (advance && op_ok) begin
         down_head_in[cidx] = dh_new;
         down_tail_in[cidx] = dt_new;
         up_head_in[cidx]   = uh_new;
         up_tail_in[cidx]   = ut_new;
      end
   end

   // result fields; an out-of-range channel answers all zeros
   always_comb begin
      s2_ok_in   = op_ok;
      s2_pop_in  = op_ok && op_pop;
      s2_dcnt_in = '0;
      s2_ucnt_in = '0;
      if (chan_ok) begin
         s2_dcnt_in = (32'(d_occ) > 255) ? mcdm_pkg::COUNT_MAX : 8'(d_occ);
         s2_ucnt_in = (32'(u_occ) > 255) ? mcdm_pkg::COUNT_MAX : 8'(u_occ);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            down_head_ff[i] <= '0;
            down_tail_ff[i] <= '0;
            up_head_ff[i]   <= '0;
            up_tail_ff[i]   <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            down_head_ff[i] <= down_head_in[i];
            down_tail_ff[i] <= down_tail_in[i];
            up_head_ff[i]   <= up_head_in[i];
            up_tail_ff[i]   <= up_tail_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         s1_kind_ff <= req_chan.kind;
         s1_chan_ff <= req_chan.channel;
         s1_word_ff <= req_chan.write_word;
      end
      if (advance) begin
         s2_ok_ff   <= s2_ok_in;
         s2_pop_ff  <= s2_pop_in;
         s2_dcnt_ff <= s2_dcnt_in;
         s2_ucnt_ff <= s2_ucnt_in;
      end
   end

   // ram read data lines up with the result register and holds while stalled
   assign rsp_chan.valid      = s2_valid_ff;
   assign rsp_chan.ok         = s2_ok_ff;
   assign rsp_chan.read_word  = s2_pop_ff ? mcdm_pkg::DATA_BITS'(ram_rdata) : '0;
   assign rsp_chan.down_count = s2_dcnt_ff;
   assign rsp_chan.up_count   = s2_ucnt_ff;

endmodule

`default_nettype wire
